>>> design/spr_pkg.sv
`timescale 1ns / 1ps

package spr_pkg;

    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPL_MAX_DEF    = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPL_BYTES    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REPL_LEN      = 2'd3;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

>>> design/stream_pattern_replace_top.sv
`timescale 1ns / 1ps
// streaming find and replace, one source byte per input item
// input channel: in_byte and string_end with in_valid/in_ready
// output channel: out_byte, byte_valid, run_last, output_end with out_valid/out_ready
// config channel: cfg_index/cfg_data with cfg_valid/cfg_ready, always ready;
//   write only while no item is in flight
// the match decision, window shift and result setup happen in the accept cycle;
//   the first result of an item is shown in the cycle after the item is accepted
// with no output stall, an item that gives one result (or none) is taken every cycle;
//   an item that gives n results holds the input while the result register drains them,
//   one per cycle, and the next item is taken in the cycle its last result leaves
// an output stall holds the current result and blocks new input once the pending
//   results of the current item are not all gone
// reset empties the window, drops pending results and loads pattern length one,
//   empty pattern bytes and an empty replacement
module stream_pattern_replace_top #(
    parameter int PATTERN_MAX     = spr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACEMENT_MAX = spr_pkg::REPL_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  spr_pkg::byte_t                  in_byte,
    input  logic                            string_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output spr_pkg::byte_t                  out_byte,
    output logic                            byte_valid,
    output logic                            run_last,
    output logic                            output_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import spr_pkg::*;

    localparam logic [LEN_W-1:0] PMAX = LEN_W'(PATTERN_MAX);
    localparam logic [LEN_W-1:0] RMAX = LEN_W'(REPLACEMENT_MAX);

    // configuration
    logic [CFG_DATA_W-1:0] pattern_reg;
    logic [LEN_W-1:0]      pattern_len_reg;
    logic [CFG_DATA_W-1:0] repl_reg;
    logic [LEN_W-1:0]      repl_len_reg;

    // window state
    byte_t            win_reg [PATTERN_MAX];
    byte_t            win_next [PATTERN_MAX];
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;

    // pending results of the current item
    byte_t            job_win_reg [PATTERN_MAX];
    logic [LEN_W-1:0] rep_pos_reg;
    logic [LEN_W-1:0] rep_cnt_reg;
    logic [LEN_W-1:0] win_pos_reg;
    logic [LEN_W-1:0] win_end_reg;
    logic             marker_reg;
    logic             job_last_reg;

    logic [LEN_W-1:0] rep_cnt_next;
    logic [LEN_W-1:0] win_start_next;
    logic [LEN_W-1:0] win_end_next;
    logic             marker_next;

    byte_t            cur_win [PATTERN_MAX];
    logic [LEN_W-1:0] cur_fill;
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen;
    logic [LEN_W-1:0] shift;
    logic             decide;
    logic             hit;

    logic  rep_active;
    logic  win_active;
    logic  final_result;
    logic  in_take;
    logic  out_take;
    byte_t sel_byte;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            pattern_len_reg <= LEN_W'(1);
            repl_reg        <= '0;
            repl_len_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PATTERN_BYTES: pattern_reg     <= cfg_data;
                REG_PATTERN_LEN:   pattern_len_reg <= cfg_data[LEN_W-1:0];
                REG_REPL_BYTES:    repl_reg        <= cfg_data;
                REG_REPL_LEN:      repl_len_reg    <= cfg_data[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // saturated lengths
    always_comb
    begin
        if (pattern_len_reg == '0)
            plen = LEN_W'(1);
        else if (pattern_len_reg > PMAX)
            plen = PMAX;
        else
            plen = pattern_len_reg;
        rlen = (repl_len_reg > RMAX) ? RMAX : repl_len_reg;
    end

    // append, compare, shift
    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if ((fill_reg == LEN_W'(j)) && (fill_reg < PMAX))
                cur_win[j] = in_byte;
            else
                cur_win[j] = win_reg[j];
        end
        cur_fill = (fill_reg < PMAX) ? fill_reg + LEN_W'(1) : fill_reg;
        decide   = (cur_fill >= plen);

        hit = decide;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if ((LEN_W'(j) < plen) && (cur_win[j] != pattern_reg[BYTE_W*j +: BYTE_W]))
                hit = 1'b0;
        end

        if (hit)
            shift = plen;
        else if (decide)
            shift = LEN_W'(1);
        else
            shift = '0;

        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            win_next[j] = cur_win[j];
            for (int s = 1; s <= PATTERN_MAX; s++)
            begin
                if ((shift == LEN_W'(s)) && (j + s < PATTERN_MAX))
                    win_next[j] = cur_win[(j + s) % PATTERN_MAX];
            end
        end
        fill_next = string_end ? '0 : cur_fill - shift;

        rep_cnt_next   = hit ? rlen : '0;
        win_start_next = hit ? plen : '0;
        if (string_end)
            win_end_next = cur_fill;
        else if (hit)
            win_end_next = plen;
        else if (decide)
            win_end_next = LEN_W'(1);
        else
            win_end_next = '0;
        marker_next = string_end && (rep_cnt_next == '0) && (win_start_next == win_end_next);
    end

    // output side
    always_comb
    begin
        rep_active = (rep_pos_reg < rep_cnt_reg);
        win_active = (win_pos_reg < win_end_reg);
        sel_byte   = '0;
        if (rep_active)
        begin
            for (int j = 0; j < REPLACEMENT_MAX; j++)
            begin
                if (rep_pos_reg == LEN_W'(j))
                    sel_byte = repl_reg[BYTE_W*j +: BYTE_W];
            end
        end
        else if (win_active)
        begin
            for (int j = 0; j < PATTERN_MAX; j++)
            begin
                if (win_pos_reg == LEN_W'(j))
                    sel_byte = job_win_reg[j];
            end
        end
        if (marker_reg)
            final_result = 1'b1;
        else if (rep_active)
            final_result = (rep_pos_reg + LEN_W'(1) == rep_cnt_reg) && !win_active;
        else
            final_result = win_active && (win_pos_reg + LEN_W'(1) == win_end_reg);
    end

    assign out_valid  = rep_active || win_active || marker_reg;
    assign out_byte   = sel_byte;
    assign byte_valid = rep_active || win_active;
    assign run_last   = final_result;
    assign output_end = final_result && job_last_reg;

    assign out_take = out_valid && out_ready;
    assign in_ready = !out_valid || (out_ready && final_result);
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            rep_pos_reg  <= '0;
            rep_cnt_reg  <= '0;
            win_pos_reg  <= '0;
            win_end_reg  <= '0;
            marker_reg   <= 1'b0;
            job_last_reg <= 1'b0;
        end
        else if (in_take)
        begin
            fill_reg     <= fill_next;
            rep_pos_reg  <= '0;
            rep_cnt_reg  <= rep_cnt_next;
            win_pos_reg  <= win_start_next;
            win_end_reg  <= win_end_next;
            marker_reg   <= marker_next;
            job_last_reg <= string_end;
        end
        else if (out_take)
        begin
            if (rep_active)
                rep_pos_reg <= rep_pos_reg + LEN_W'(1);
            else if (win_active)
                win_pos_reg <= win_pos_reg + LEN_W'(1);
            marker_reg <= 1'b0;
        end
    end

    // window payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int j = 0; j < PATTERN_MAX; j++)
            begin
                win_reg[j]     <= win_next[j];
                job_win_reg[j] <= cur_win[j];
            end
        end
    end

endmodule
